>>> hdl/pcrf_pkg.sv
package pcrf_pkg;

  // default number of capture slots per session
  localparam int unsigned MAX_CAPTURE_DEF = 16;

  // width used to compare the sequence number against count plus one
  localparam int unsigned SEQ_CMP_W = 9;

  // configuration port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_HOST    = 2'd1;
  localparam logic [1:0] REG_REMOTE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_NOT_CONFIGURED = 4'd0,
    ST_REJECTED       = 4'd1,
    ST_REDUNDANT      = 4'd2,
    ST_BEGIN          = 4'd3,
    ST_ALREADY_ON     = 4'd4,
    ST_FULL           = 4'd5,
    ST_CAPTURED       = 4'd6,
    ST_COMMAND        = 4'd7,
    ST_NOT_ON         = 4'd8,
    ST_END            = 4'd9,
    ST_UNKNOWN        = 4'd10
  } status_e;

  typedef struct packed {
    logic [15:0] dst_addr;
    logic [15:0] src_addr;
    logic [7:0]  ack_id;
    logic [7:0]  seq_num;
    kind_e       packet_kind;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  store_slot;
    logic [4:0]  end_count;
  } out_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] host_address;
    logic [15:0] remote_address;
  } cfg_t;

endpackage

>>> hdl/pcrf_regs.sv
module pcrf_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcrf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pcrf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pcrf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output pcrf_pkg::cfg_t                   cfg_o
);

  logic        enabled_q;
  logic [15:0] host_q;
  logic [15:0] remote_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      host_q    <= 16'd0;
      remote_q  <= 16'd0;
    end else if (wr_en) begin
      case (reg_idx)
        pcrf_pkg::REG_ENABLED: enabled_q <= pwdata[0];
        pcrf_pkg::REG_HOST:    host_q    <= pwdata[15:0];
        pcrf_pkg::REG_REMOTE:  remote_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      pcrf_pkg::REG_ENABLED: prdata = {31'd0, enabled_q};
      pcrf_pkg::REG_HOST:    prdata = {16'd0, host_q};
      pcrf_pkg::REG_REMOTE:  prdata = {16'd0, remote_q};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.enabled        = enabled_q;
  assign cfg_o.host_address   = host_q;
  assign cfg_o.remote_address = remote_q;

endmodule

>>> hdl/pcrf_core.sv
module pcrf_core #(
  parameter int unsigned MAX_CAPTURE = pcrf_pkg::MAX_CAPTURE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcrf_pkg::cfg_t cfg_i,
  input  pcrf_pkg::in_t  req_i,
  input  logic           fire_i,
  output pcrf_pkg::out_t rsp_o
);

  localparam int unsigned CntW = $clog2(MAX_CAPTURE + 1);

  logic            capturing_q, capturing_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      session_ack_q, session_ack_d;
  logic [7:0]      last_ack_q, last_ack_d;
  logic [7:0]      last_seq_q, last_seq_d;

  logic                          addr_ok;
  logic                          redundant;
  logic                          session_match;
  logic                          full;
  logic                          in_order;
  logic [pcrf_pkg::SEQ_CMP_W-1:0] next_seq;
  logic [7:0]                    count_ext;

  assign addr_ok       = (req_i.dst_addr == cfg_i.host_address) &&
                         (req_i.src_addr == cfg_i.remote_address);
  assign redundant     = (req_i.ack_id == last_ack_q) &&
                         (req_i.seq_num == last_seq_q);
  assign session_match = req_i.ack_id == session_ack_q;
  assign full          = count_q >= CntW'(MAX_CAPTURE);
  assign next_seq      = pcrf_pkg::SEQ_CMP_W'(count_q) + 1'b1;
  assign in_order      = pcrf_pkg::SEQ_CMP_W'(req_i.seq_num) == next_seq;
  assign count_ext     = 8'(count_q);

  // header classification and session update
  always_comb begin
    capturing_d   = capturing_q;
    count_d       = count_q;
    session_ack_d = session_ack_q;
    last_ack_d    = last_ack_q;
    last_seq_d    = last_seq_q;
    rsp_o.status     = pcrf_pkg::ST_UNKNOWN;
    rsp_o.store_slot = 4'd0;
    rsp_o.end_count  = 5'd0;
    if (!cfg_i.enabled) begin
      rsp_o.status = pcrf_pkg::ST_NOT_CONFIGURED;
    end else if (!addr_ok) begin
      rsp_o.status = pcrf_pkg::ST_REJECTED;
    end else if (redundant) begin
      rsp_o.status = pcrf_pkg::ST_REDUNDANT;
    end else begin
      last_ack_d = req_i.ack_id;
      last_seq_d = req_i.seq_num;
      case (req_i.packet_kind)
        pcrf_pkg::KIND_BEGIN: begin
          if (!capturing_q) begin
            capturing_d   = 1'b1;
            count_d       = '0;
            session_ack_d = req_i.ack_id;
            rsp_o.status  = pcrf_pkg::ST_BEGIN;
          end else begin
            rsp_o.status = pcrf_pkg::ST_ALREADY_ON;
          end
        end
        pcrf_pkg::KIND_DATA: begin
          if (capturing_q && session_match) begin
            if (full) begin
              rsp_o.status = pcrf_pkg::ST_FULL;
            end else if (!in_order) begin
              rsp_o.status = pcrf_pkg::ST_REJECTED;
            end else begin
              rsp_o.store_slot = count_ext[3:0];
              count_d          = count_q + 1'b1;
              rsp_o.status     = pcrf_pkg::ST_CAPTURED;
            end
          end else if (!session_match) begin
            rsp_o.status = pcrf_pkg::ST_COMMAND;
          end else begin
            rsp_o.status = pcrf_pkg::ST_REJECTED;
          end
        end
        pcrf_pkg::KIND_END: begin
          if (!capturing_q) begin
            rsp_o.status = pcrf_pkg::ST_NOT_ON;
          end else begin
            rsp_o.end_count = count_ext[4:0];
            capturing_d     = 1'b0;
            count_d         = '0;
            session_ack_d   = 8'h00;
            rsp_o.status    = pcrf_pkg::ST_END;
          end
        end
        default: begin
          rsp_o.status = pcrf_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

  // session state, updated once per processed header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q   <= 1'b0;
      count_q       <= '0;
      session_ack_q <= 8'h00;
      last_ack_q    <= 8'h00;
      last_seq_q    <= 8'h00;
    end else if (fire_i) begin
      capturing_q   <= capturing_d;
      count_q       <= count_d;
      session_ack_q <= session_ack_d;
      last_ack_q    <= last_ack_d;
      last_seq_q    <= last_seq_d;
    end
  end

  // count stays within the slot range
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_CAPTURE))
    else $error("capture count above maximum");

  // no open session means nothing captured
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !capturing_q |-> (count_q == '0))
    else $error("count nonzero with no session");

  // a captured header bumps the count by one
  a_capture_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && rsp_o.status == pcrf_pkg::ST_CAPTURED) |=>
      (count_q == $past(count_q) + 1'b1))
    else $error("capture did not advance count");

  // state holds when no header is processed
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(count_q) && $stable(capturing_q) && $stable(last_ack_q)))
    else $error("state changed without a header");

endmodule

>>> hdl/packet_capture_receive_filter_top.sv
// Packet capture receive filter. Each request is one received packet header
// and yields exactly one result (status, capture slot, end count). Headers are
// taken into an input register, classified combinationally against the
// configuration and the session state, and the result lands in an output
// register; the block accepts one header every clock while the output side is
// not stalled, and each header passes through the input register and its result
// through the output register, which holds it until it is taken. The session
// state is updated once for each processed header. Configuration goes through
// an APB-style port (enabled at 0x0, host address at 0x4, remote address at
// 0x8) and is to be written only while no header is in flight.
module packet_capture_receive_filter_top #(
  parameter int unsigned MAX_CAPTURE = pcrf_pkg::MAX_CAPTURE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcrf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pcrf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pcrf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pcrf_pkg::in_t                    in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pcrf_pkg::out_t                   out_rsp_o
);

  pcrf_pkg::cfg_t cfg;
  pcrf_pkg::in_t  in_q;
  pcrf_pkg::out_t rsp;
  pcrf_pkg::out_t out_q;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           advance;
  logic           fire;
  logic           in_take;

  pcrf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcrf_core #(
    .MAX_CAPTURE (MAX_CAPTURE)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (in_q),
    .fire_i (fire),
    .rsp_o  (rsp)
  );

  // pipeline flow control
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost");

  // a held header is not processed while the output is blocked
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !fire)
    else $error("header processed into a full result register");

  // full pipeline only accepts when it drains
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !in_ready_o)
    else $error("input accepted with full input register");

endmodule

>>> tb/tb_packet_capture_receive_filter_top.sv
`timescale 1ns / 100ps

module tb_packet_capture_receive_filter_top;
  import pcrf_pkg::*;

  localparam int unsigned CAPTURE_SLOTS = MAX_CAPTURE_DEF;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic [1:0]  REG_SPARE     = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_rsp_o;

  // shadow of the filter registers and session state
  logic        cfg_enabled;
  logic [15:0] cfg_host;
  logic [15:0] cfg_remote;
  logic        sess_open;
  int          sess_count;
  logic [7:0]  sess_ack;
  logic [7:0]  prev_ack;
  logic [7:0]  prev_seq;

  out_t status_due_q[$];
  in_t  last_sent;
  int   n_items;
  int   n_results;
  int   n_errors;
  int   status_hits[16];
  int   quiet_cycles;

  // traffic shaping knobs
  bit   tx_idle_on;
  bit   rx_idle_on;
  bit   hold_request;
  int   hold_left;
  int   stall_left;
  int   run_left;

  packet_capture_receive_filter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // expected status of one header, advances the session shadow
  function automatic out_t classify_header(input in_t h);
    out_t r;
    r = '0;
    r.status = ST_UNKNOWN;
    if (!cfg_enabled) begin
      r.status = ST_NOT_CONFIGURED;
    end else if (h.dst_addr != cfg_host || h.src_addr != cfg_remote) begin
      r.status = ST_REJECTED;
    end else if (h.ack_id == prev_ack && h.seq_num == prev_seq) begin
      r.status = ST_REDUNDANT;
    end else begin
      prev_ack = h.ack_id;
      prev_seq = h.seq_num;
      case (h.packet_kind)
        KIND_BEGIN: begin
          if (!sess_open) begin
            sess_open  = 1'b1;
            sess_count = 0;
            sess_ack   = h.ack_id;
            r.status   = ST_BEGIN;
          end else begin
            r.status = ST_ALREADY_ON;
          end
        end
        KIND_DATA: begin
          if (sess_open && h.ack_id == sess_ack) begin
            if (sess_count >= CAPTURE_SLOTS) begin
              r.status = ST_FULL;
            end else if (int'(h.seq_num) != sess_count + 1) begin
              r.status = ST_REJECTED;
            end else begin
              r.store_slot = sess_count[3:0];
              sess_count++;
              r.status = ST_CAPTURED;
            end
          end else if (h.ack_id != sess_ack) begin
            r.status = ST_COMMAND;
          end else begin
            r.status = ST_REJECTED;
          end
        end
        KIND_END: begin
          if (!sess_open) begin
            r.status = ST_NOT_ON;
          end else begin
            r.end_count = sess_count[4:0];
            sess_open  = 1'b0;
            sess_count = 0;
            sess_ack   = '0;
            r.status   = ST_END;
          end
        end
        default: r.status = ST_UNKNOWN;
      endcase
    end
    status_hits[r.status]++;
    return r;
  endfunction

  function automatic in_t build_hdr(input logic [15:0] dest, input logic [15:0] src,
                                    input kind_e kind, input logic [7:0] ack,
                                    input logic [7:0] seq);
    in_t h;
    h.dst_addr    = dest;
    h.src_addr    = src;
    h.ack_id      = ack;
    h.seq_num     = seq;
    h.packet_kind = kind;
    return h;
  endfunction

  function automatic in_t random_header();
    in_t h;
    h.dst_addr    = $urandom_range(0, 1) ? cfg_host : 16'($urandom);
    h.src_addr    = $urandom_range(0, 1) ? cfg_remote : 16'($urandom);
    h.ack_id      = 8'($urandom);
    h.seq_num     = 8'($urandom);
    h.packet_kind = kind_e'($urandom_range(0, 3));
    return h;
  endfunction

  // one request on the header channel, expectation queued at acceptance
  task automatic send_header(input in_t h);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= h;
    do @(posedge clk_i); while (!in_ready_o);
    status_due_q.push_back(classify_header(h));
    last_sent = h;
    n_items++;
  endtask

  // drop valid and let everything in flight come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb setup and access cycles, register taken at the access edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLED: cfg_enabled = data[0];
      REG_HOST:    cfg_host    = data[15:0];
      REG_REMOTE:  cfg_remote  = data[15:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk, only the register width counts
  task automatic set_filter(input logic en, input logic [15:0] host,
                            input logic [15:0] remote);
    logic [31:0] word;
    word = $urandom;
    word[0] = en;
    write_reg(REG_ENABLED, word);
    word = $urandom;
    word[15:0] = host;
    write_reg(REG_HOST, word);
    word = $urandom;
    word[15:0] = remote;
    write_reg(REG_REMOTE, word);
  endtask

  // block still unconfigured after reset
  task automatic test_disabled();
    send_header(build_hdr(16'h0000, 16'h0000, KIND_BEGIN, 8'h00, 8'h01));
    send_header(build_hdr(16'hFFFF, 16'hFFFF, KIND_DATA, 8'hFF, 8'hFF));
    send_header(build_hdr(16'h0000, 16'hFFFF, KIND_END, 8'h00, 8'hFF));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_OTHER, 8'hFF, 8'h00));
  endtask

  // every status but not configured and full, and the session corner cases once
  task automatic test_directed_session();
    // header equal to the reset values of the last ack and sequence
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'h00, 8'h00));
    send_header(build_hdr(16'hFFFE, 16'h0000, KIND_BEGIN, 8'h11, 8'h22));
    send_header(build_hdr(16'hFFFF, 16'h0001, KIND_BEGIN, 8'h11, 8'h22));
    // session ack matches while nothing is open
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'h00, 8'h05));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'h5A, 8'hFF));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_OTHER, 8'hFF, 8'h00));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_END, 8'h01, 8'h01));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_BEGIN, 8'hA5, 8'h00));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_BEGIN, 8'hA5, 8'h00));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_BEGIN, 8'hA6, 8'h09));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'hA5, 8'h01));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'hA5, 8'h01));
    // out of order, then the right one
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'hA5, 8'h03));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'hA5, 8'h02));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'h3C, 8'h02));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_OTHER, 8'hA5, 8'h80));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_DATA, 8'hA5, 8'h03));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_END, 8'hFF, 8'hFF));
    send_header(build_hdr(16'hFFFF, 16'h0000, KIND_END, 8'hFE, 8'hFF));
  endtask

  // mostly well formed sessions with some broken items, rest noise
  task automatic test_random_traffic(input int n);
    int          stop_at;
    int          len;
    int          next_seq;
    logic [7:0]  sack;
    in_t         h;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        sack = 8'($urandom);
        send_header(build_hdr(cfg_host, cfg_remote, KIND_BEGIN, sack, 8'($urandom)));
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 8);
        next_seq = 1;
        while (next_seq <= len) begin
          case ($urandom_range(0, 19))
            0: send_header(build_hdr(cfg_host, cfg_remote, KIND_DATA, sack, 8'($urandom)));
            1: send_header(build_hdr(cfg_host, cfg_remote, KIND_DATA,
                                     sack ^ 8'($urandom_range(1, 255)), 8'(next_seq)));
            2: send_header(last_sent);
            3: send_header(build_hdr(cfg_host, cfg_remote, KIND_OTHER,
                                     8'($urandom), 8'($urandom)));
            4: send_header(build_hdr(cfg_host, cfg_remote, KIND_BEGIN,
                                     8'($urandom), 8'($urandom)));
            5: begin
              // one address bit off
              h = build_hdr(cfg_host, cfg_remote, KIND_DATA, sack, 8'(next_seq));
              if ($urandom_range(0, 1))
                h.dst_addr ^= 16'(1) << $urandom_range(0, 15);
              else
                h.src_addr ^= 16'(1) << $urandom_range(0, 15);
              send_header(h);
            end
            default: begin
              send_header(build_hdr(cfg_host, cfg_remote, KIND_DATA, sack, 8'(next_seq)));
              next_seq++;
            end
          endcase
        end
        if ($urandom_range(0, 7) != 0)
          send_header(build_hdr(cfg_host, cfg_remote, KIND_END, 8'($urandom), 8'($urandom)));
      end else begin
        repeat ($urandom_range(1, 4)) send_header(random_header());
      end
    end
  endtask

  // result side held off while headers keep coming, input has to stall
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    test_random_traffic(40);
  endtask

  // result side: random stall bursts, plus one long hold on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (!rx_idle_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      out_ready_i <= 1'b1;
      run_left--;
    end else begin
      stall_left = $urandom_range(1, 7) - 1;
      run_left = $urandom_range(1, 24);
      out_ready_i <= 1'b0;
    end
  end

  // compare each result with the oldest pending status
  always @(posedge clk_i) begin : check_rsp
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (status_due_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("[%0t] result with nothing pending: status %0d slot %0d count %0d",
                   $realtime, out_rsp_o.status, out_rsp_o.store_slot, out_rsp_o.end_count);
      end else begin
        want = status_due_q.pop_front();
        if (out_rsp_o.status !== want.status || out_rsp_o.store_slot !== want.store_slot ||
            out_rsp_o.end_count !== want.end_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display("[%0t] bad result: want status %0d slot %0d count %0d, got %0d %0d %0d",
                     $realtime, want.status, want.store_slot, want.end_count,
                     out_rsp_o.status, out_rsp_o.store_slot, out_rsp_o.end_count);
        end
      end
    end
  end

  // cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results pending",
               quiet_cycles, status_due_q.size());
      $display("packet_capture_receive_filter_top: mismatch");
      $finish;
    end
  end

  initial begin
    cfg_enabled = 1'b0;
    cfg_host    = '0;
    cfg_remote  = '0;
    sess_open   = 1'b0;
    sess_count  = 0;
    sess_ack    = '0;
    prev_ack    = '0;
    prev_seq    = '0;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled();
    wait_idle();
    set_filter(1'b1, 16'hFFFF, 16'h0000);
    write_reg(REG_SPARE, $urandom);
    test_directed_session();
    wait_idle();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    set_filter(1'b1, 16'($urandom), 16'($urandom));
    test_random_traffic(330);
    test_output_backpressure();
    test_random_traffic(230);
    wait_idle();

    set_filter(1'b1, 16'h0000, 16'hFFFF);
    test_random_traffic(150);
    wait_idle();

    // disabled in the middle of whatever session is open
    set_filter(1'b0, 16'h0000, 16'hFFFF);
    test_random_traffic(20);
    wait_idle();

    // final stretch without idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_filter(1'b1, 16'($urandom), 16'($urandom));
    test_random_traffic(150);
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("sent %0d headers, checked %0d results, %0d mismatches",
             n_items, n_results, n_errors);
    $display("captured %0d, slot limit hit %0d, sessions closed %0d, commands %0d",
             status_hits[ST_CAPTURED], status_hits[ST_FULL], status_hits[ST_END],
             status_hits[ST_COMMAND]);
    if (n_errors == 0 && status_due_q.size() == 0)
      $display("packet_capture_receive_filter_top: match");
    else
      $display("packet_capture_receive_filter_top: mismatch");
    $finish;
  end

endmodule
